### hdl/shpta_pkg.sv
// package for the surge/heading pid thrust allocator
// types, constants and fixed-point helpers; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package shpta_pkg;

  localparam int FracBitsDef = 16;
  localparam int GainW = 24;
  localparam int ThrW = 23;
  localparam int AddrW = 5;

  localparam logic [AddrW-1:0] AddrSpeedP = 5'd0;
  localparam logic [AddrW-1:0] AddrSpeedI = 5'd4;
  localparam logic [AddrW-1:0] AddrSpeedD = 5'd8;
  localparam logic [AddrW-1:0] AddrHeadP  = 5'd12;
  localparam logic [AddrW-1:0] AddrHeadD  = 5'd16;

  localparam logic [GainW-1:0] RstSpeedP = 24'd72090;
  localparam logic [GainW-1:0] RstSpeedI = 24'd13107;
  localparam logic [GainW-1:0] RstSpeedD = 24'd6554;
  localparam logic [GainW-1:0] RstHeadP  = 24'd52429;
  localparam logic [GainW-1:0] RstHeadD  = 24'd196608;

  // constants at 24 fraction bits
  localparam longint KXuLo = -64'sd419430400;
  localparam longint KXuHi = 64'sd1082969293;
  localparam longint KXuuHi = -64'sd1189840159;
  localparam longint KSpeedSw = 64'sd20132659;
  localparam longint KNr = -64'sd8724152;
  localparam longint KPi = 64'sd52707168;
  localparam longint KMx = 64'sd541065216;
  localparam longint KMy = 64'sd891373486;
  localparam longint KIz = 64'sd115595018;
  localparam longint KUv = -64'sd350308270;
  localparam longint KHalfDt = 64'sd83886;
  localparam longint KInvB = 64'sd40920039;
  localparam longint KInv2c = 64'sd10754626;
  localparam longint KInvBc = 64'sd52461589;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT, ST_MUL, ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic sqrt_go;
    logic mul_go;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic sqrt_done;
    logic mul_done;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] clampr(input logic signed [31:0] x,
      input logic signed [31:0] lo, input logic signed [31:0] hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

endpackage
`default_nettype wire

### hdl/surge_heading_pid_thrust_allocator.sv
// top level: apb gain registers, controller and datapath
// depends on shpta_pkg, shpta_ctrl, shpta_dp
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | handshake
// in      | input     | in_valid_i / in_stall_o, one transfer per tick
// out     | output    | out_valid_o / out_stall_i, one transfer per active tick
// cfg     | apb       | psel/penable/pwrite, pready always high
// an active tick's result passes the bit-serial root (32 iterations, squares
// formed at the transfer), then 20 steps of one shared 33x33 multiplier, then
// the output load. the block takes no new tick while one is still in
// flight.
// inactive ticks (flags not both 1) are taken without computing and give nothing.
// reset clears the state, the gains to defaults and the output valid.
// a stalled result holds; a new tick waits until the result is taken.
module surge_heading_pid_thrust_allocator #(
  parameter int FracBits = shpta_pkg::FracBitsDef
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        in_valid_i,
  output logic              in_stall_o,
  input  wire  logic signed [31:0] desired_speed_i, desired_heading_i, heading_i,
  input  wire  logic signed [31:0] surge_speed_i, sway_speed_i, yaw_rate_i,
  input  wire  logic [7:0]  test_flag_i, link_flag_i,
  output logic              out_valid_o,
  input  wire  logic        out_stall_i,
  output logic signed [shpta_pkg::ThrW-1:0] starboard_thrust_o, port_thrust_o,
  output logic signed [31:0] speed_error_o, heading_error_o,
  input  wire  logic        psel,
  input  wire  logic        penable,
  input  wire  logic        pwrite,
  input  wire  logic [shpta_pkg::AddrW-1:0] paddr,
  input  wire  logic [31:0] pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import shpta_pkg::*;

  logic [GainW-1:0] kp_q, ki_q, kd_q, hp_q, hd_q;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  // gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= RstSpeedP; ki_q <= RstSpeedI; kd_q <= RstSpeedD;
      hp_q <= RstHeadP; hd_q <= RstHeadD;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        AddrSpeedP: kp_q <= pwdata[GainW-1:0];
        AddrSpeedI: ki_q <= pwdata[GainW-1:0];
        AddrSpeedD: kd_q <= pwdata[GainW-1:0];
        AddrHeadP:  hp_q <= pwdata[GainW-1:0];
        AddrHeadD:  hd_q <= pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrSpeedP: prdata = 32'(kp_q);
      AddrSpeedI: prdata = 32'(ki_q);
      AddrSpeedD: prdata = 32'(kd_q);
      AddrHeadP:  prdata = 32'(hp_q);
      AddrHeadD:  prdata = 32'(hd_q);
      default:    prdata = '0;
    endcase
  end

  // a result waiting blocks the next tick
  shpta_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_busy_i(out_valid_o), .sts_i(sts), .cmd_o(cmd)
  );

  shpta_dp #(.FracBits(FracBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .ud_i(desired_speed_i), .psid_i(desired_heading_i), .th_i(heading_i),
    .u_i(surge_speed_i), .v_i(sway_speed_i), .r_i(yaw_rate_i),
    .tf_i(test_flag_i), .lf_i(link_flag_i),
    .kp_i(kp_q), .ki_i(ki_q), .kd_i(kd_q), .hp_i(hp_q), .hd_i(hd_q),
    .out_stall_i, .out_valid_o,
    .stbd_o(starboard_thrust_o), .port_o(port_thrust_o),
    .eu_o(speed_error_o), .epsi_o(heading_error_o)
  );
endmodule
`default_nettype wire

### hdl/shpta_ctrl.sv
// controller state machine for the allocator
// depends on shpta_pkg
`timescale 1ns / 1ps
`default_nettype none
module shpta_ctrl (
  input  wire  logic           clk_i,
  input  wire  logic           rst_ni,
  input  wire  logic           in_valid_i,
  output logic                 in_stall_o,
  input  wire  logic           out_busy_i,
  input  wire  shpta_pkg::sts_t sts_i,
  output shpta_pkg::cmd_t      cmd_o
);
  import shpta_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i && !out_busy_i && sts_i.active) state_d = ST_SQRT;
      ST_SQRT: if (sts_i.sqrt_done) state_d = ST_MUL;
      ST_MUL:  if (sts_i.mul_done) state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = out_busy_i;
        cmd_o.load = in_valid_i && !out_busy_i && sts_i.active;
      end
      ST_SQRT: cmd_o.sqrt_go = 1'b1;
      ST_MUL:  cmd_o.mul_go = 1'b1;
      ST_OUT:  cmd_o.finish = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

### hdl/shpta_dp.sv
// datapath: bit-serial square root, shared multiplier sequencer, output register
// depends on shpta_pkg
`timescale 1ns / 1ps
`default_nettype none
module shpta_dp #(
  parameter int FracBits = shpta_pkg::FracBitsDef
) (
  input  wire  logic                         clk_i,
  input  wire  logic                         rst_ni,
  input  wire  shpta_pkg::cmd_t              cmd_i,
  output shpta_pkg::sts_t                    sts_o,
  input  wire  logic signed [31:0]           ud_i, psid_i, th_i, u_i, v_i, r_i,
  input  wire  logic [7:0]                   tf_i, lf_i,
  input  wire  logic [shpta_pkg::GainW-1:0]  kp_i, ki_i, kd_i, hp_i, hd_i,
  input  wire  logic                         out_stall_i,
  output logic                               out_valid_o,
  output logic signed [shpta_pkg::ThrW-1:0]  stbd_o, port_o,
  output logic signed [31:0]                 eu_o, epsi_o
);
  import shpta_pkg::*;

  localparam int Sh = 24 - FracBits;
  localparam longint One = longint'(1) << FracBits;
  localparam logic [4:0] LastStep = 5'd20;

  function automatic logic signed [31:0] kq(input longint c);
    longint t;
    t = (Sh == 0) ? c : ((c + (longint'(1) << (Sh - 1))) >>> Sh);
    return t[31:0];
  endfunction

  logic signed [31:0] ud_q, psid_q, th_q, u_q, v_q, r_q;
  logic signed [31:0] eint_q, prev_q, eint_n_q, nr_q, a_q, mag_q;
  logic signed [35:0] uau_acc_q, uapsi_acc_q, tx_acc_q, tz_acc_q, tp_acc_q, ts_acc_q;
  logic [63:0] sq_n_q, sq_res_q, sq_bit_q;
  logic [5:0] sq_cnt_q;
  logic [4:0] step_q;

  assign sts_o.active = (tf_i == 8'd1) && (lf_i == 8'd1);
  assign sts_o.sqrt_done = (sq_cnt_q == 6'd32);
  assign sts_o.mul_done = (step_q == LastStep);

  // squares of the speed magnitudes, formed at the input transfer
  logic [31:0] ua_in, va_in;
  logic [63:0] sq_in;
  assign ua_in = u_i[31] ? 32'(-u_i) : 32'(u_i);
  assign va_in = v_i[31] ? 32'(-v_i) : 32'(v_i);
  assign sq_in = 64'(ua_in) * 64'(ua_in) + 64'(va_in) * 64'(va_in);

  // working values
  logic signed [32:0] uabs, dpsi;
  logic signed [31:0] xu, xuu, eu, sume, ed, epsi, uau, uapsi, txf, tzf, tp, ts;
  always_comb begin
    uabs = u_q < 0 ? -33'(u_q) : 33'(u_q);
    if (uabs > 33'(kq(KSpeedSw))) begin
      xu = kq(KXuHi); xuu = kq(KXuuHi);
    end else begin
      xu = kq(KXuLo); xuu = '0;
    end
    eu = sat32(66'(ud_q) - 66'(u_q));
    sume = sat32(66'(eu) + 66'(prev_q));
    ed = sat32(66'sd100 * 66'(sat32(66'(eu) - 66'(prev_q))));
    dpsi = 33'(psid_q) - 33'(th_q);
    if (dpsi > 33'(kq(KPi))) dpsi = dpsi - 33'(2) * 33'(kq(KPi));
    else if (dpsi < -33'(kq(KPi))) dpsi = dpsi + 33'(2) * 33'(kq(KPi));
    epsi = sat32(66'(dpsi));
    uau = sat32(66'(uau_acc_q));
    uapsi = sat32(66'(uapsi_acc_q));
    txf = clampr(sat32(66'(tx_acc_q)), 32'(-60 * One), 32'(73 * One));
    tzf = clampr(sat32(66'(tz_acc_q)), 32'(-14 * One), 32'(14 * One));
    if (ud_q == 0) begin txf = '0; tzf = '0; end
    tp = clampr(sat32(66'(tp_acc_q)), 32'(-30 * One), 32'(73 * (One / 2)));
    ts = clampr(sat32(66'(ts_acc_q)), 32'(-30 * One), 32'(73 * (One / 2)));
  end

  logic [63:0] sq_t;
  assign sq_t = sq_res_q + sq_bit_q;

  // one shared multiplier, gains are unsigned with 16 fraction bits
  logic signed [32:0] m_a, m_b;
  logic m_gain;
  logic signed [65:0] m_full;
  logic signed [31:0] m_p;
  always_comb begin
    m_a = '0; m_b = '0; m_gain = 1'b0;
    case (step_q)
      5'd0:  begin m_a = 33'(kq(KNr)); m_b = 33'(mag_q); end
      5'd1:  begin m_a = 33'(kq(KHalfDt)); m_b = 33'(sume); end
      5'd2:  begin m_a = 33'(kp_i); m_b = 33'(eu); m_gain = 1'b1; end
      5'd3:  begin m_a = 33'(ki_i); m_b = 33'(eint_n_q); m_gain = 1'b1; end
      5'd4:  begin m_a = 33'(kd_i); m_b = 33'(ed); m_gain = 1'b1; end
      5'd5:  begin m_a = 33'(hp_i); m_b = 33'(epsi); m_gain = 1'b1; end
      5'd6:  begin m_a = 33'(hd_i); m_b = -33'(r_q); m_gain = 1'b1; end
      5'd7:  begin m_a = 33'(kq(KMx)); m_b = 33'(uau); end
      5'd8:  begin m_a = 33'(v_q); m_b = 33'(r_q); end
      5'd9:  begin m_a = 33'(kq(KMy)); m_b = 33'(a_q); end
      5'd10: begin m_a = uabs; m_b = 33'(u_q); end
      5'd11: begin m_a = 33'(xuu); m_b = 33'(a_q); end
      5'd12: begin m_a = 33'(xu); m_b = 33'(u_q); end
      5'd13: begin m_a = 33'(kq(KIz)); m_b = 33'(uapsi); end
      5'd14: begin m_a = 33'(u_q); m_b = 33'(v_q); end
      5'd15: begin m_a = 33'(kq(KUv)); m_b = 33'(a_q); end
      5'd16: begin m_a = 33'(nr_q); m_b = 33'(r_q); end
      5'd17: begin m_a = 33'(kq(KInvB)); m_b = 33'(tzf); end
      5'd18: begin m_a = 33'(kq(KInv2c)); m_b = 33'(txf); end
      5'd19: begin m_a = 33'(kq(KInvBc)); m_b = 33'(tzf); end
      default: ;
    endcase
    m_full = 66'(m_a) * 66'(m_b);
    m_p = sat32(m_gain ? (m_full >>> 16) : (m_full >>> FracBits));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ud_q <= ud_i; psid_q <= psid_i; th_q <= th_i;
      u_q <= u_i; v_q <= v_i; r_q <= r_i;
      sq_n_q <= sq_in;
      sq_res_q <= '0; sq_bit_q <= 64'd1 << 62;
    end else if (cmd_i.sqrt_go && sq_cnt_q != 6'd32) begin
      if (sq_n_q >= sq_t) begin
        sq_n_q <= sq_n_q - sq_t;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else sq_res_q <= sq_res_q >> 1;
      sq_bit_q <= sq_bit_q >> 2;
    end
    if (cmd_i.sqrt_go && sq_cnt_q == 6'd31) mag_q <= sat32(66'(sq_res_q >> 1) +
        66'(((sq_n_q >= sq_t) ? 64'd1 : 64'd0)));
    if (cmd_i.mul_go) begin
      case (step_q)
        5'd0:  nr_q <= m_p;
        5'd1:  eint_n_q <= sat32(66'(m_p) + 66'(eint_q));
        5'd2:  uau_acc_q <= 36'(m_p);
        5'd3:  uau_acc_q <= uau_acc_q + 36'(m_p);
        5'd4:  uau_acc_q <= uau_acc_q + 36'(m_p);
        5'd5:  uapsi_acc_q <= 36'(m_p);
        5'd6:  uapsi_acc_q <= uapsi_acc_q + 36'(m_p);
        5'd7:  tx_acc_q <= 36'(m_p);
        5'd8:  a_q <= m_p;
        5'd9:  tx_acc_q <= tx_acc_q - 36'(m_p);
        5'd10: a_q <= m_p;
        5'd11: tx_acc_q <= tx_acc_q - 36'(m_p);
        5'd12: tx_acc_q <= tx_acc_q - 36'(m_p);
        5'd13: tz_acc_q <= 36'(m_p);
        5'd14: a_q <= m_p;
        5'd15: tz_acc_q <= tz_acc_q - 36'(m_p);
        5'd16: tz_acc_q <= tz_acc_q - 36'(m_p);
        5'd17: tp_acc_q <= 36'(txf >>> 1) + 36'(m_p);
        5'd18: ts_acc_q <= 36'(m_p);
        5'd19: ts_acc_q <= ts_acc_q - 36'(m_p);
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      stbd_o <= ts[ThrW-1:0]; port_o <= tp[ThrW-1:0];
      eu_o <= eu; epsi_o <= epsi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eint_q <= '0; prev_q <= '0; out_valid_o <= 1'b0;
      sq_cnt_q <= '0; step_q <= '0;
    end else begin
      if (cmd_i.load) begin sq_cnt_q <= '0; step_q <= '0; end
      else begin
        if (cmd_i.sqrt_go && sq_cnt_q != 6'd32) sq_cnt_q <= sq_cnt_q + 6'd1;
        if (cmd_i.mul_go && step_q != LastStep) step_q <= step_q + 5'd1;
      end
      if (cmd_i.finish) begin
        out_valid_o <= 1'b1;
        eint_q <= (ud_q == 0) ? '0 : eint_n_q;
        prev_q <= (ud_q == 0) ? '0 : eu;
      end else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end
endmodule
`default_nettype wire
